### hdl/blzd_pkg.sv
// ----------------------------------------------------------------------------
// blzd_pkg
// Shared types and constants for the backward LZ bit decompressor.
// ----------------------------------------------------------------------------
package blzd_pkg;

    localparam int WINDOW_DEPTH = 32768;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int LEN_W        = 23;
    localparam int ADDR_W       = 22;
    localparam int FIELD_W      = 15;
    localparam int CFG_AW       = 5;
    localparam int CFG_DW       = 32;

    localparam logic [LEN_W-1:0] OUTPUT_LENGTH_RESET = 23'd512;
    localparam logic [3:0]       OFFSET_WIDTH_RESET  = 4'd9;
    localparam logic [3:0]       SHORT_OFFSET_WIDTH  = 4'd7;
    localparam logic [3:0]       BYTE_BITS           = 4'd8;

    typedef enum logic [2:0] {
        REG_SKIP_BITS     = 3'd0,
        REG_OUTPUT_LENGTH = 3'd1,
        REG_OFFSET_W1     = 3'd2,
        REG_OFFSET_W2     = 3'd3,
        REG_OFFSET_W3     = 3'd4,
        REG_OFFSET_W4     = 3'd5
    } reg_index_t;

    typedef enum logic [9:0] {
        PH_SKIP    = 10'b00_0000_0001,
        PH_FLAG    = 10'b00_0000_0010,
        PH_LITLEN  = 10'b00_0000_0100,
        PH_LITBYTE = 10'b00_0000_1000,
        PH_MLEN    = 10'b00_0001_0000,
        PH_MFLAG   = 10'b00_0010_0000,
        PH_MOFS    = 10'b00_0100_0000,
        PH_MEXT    = 10'b00_1000_0000,
        PH_COPY    = 10'b01_0000_0000,
        PH_DONE    = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0]       skip_bits;
        logic [LEN_W-1:0] output_length;
        logic [3:0]       offset_width_1;
        logic [3:0]       offset_width_2;
        logic [3:0]       offset_width_3;
        logic [3:0]       offset_width_4;
    } cfg_t;

    typedef struct packed {
        logic       command;
        logic [7:0] pbyte;
    } item_t;

endpackage

### hdl/blzd_regs.sv
// ----------------------------------------------------------------------------
// blzd_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module blzd_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [blzd_pkg::CFG_AW-1:0] paddr,
    input  logic [blzd_pkg::CFG_DW-1:0] pwdata,
    output logic [blzd_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output blzd_pkg::cfg_t             cfg,
    output logic                       cfg_restart
);
    import blzd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    reg_index_t idx;
    logic       idx_ok;
    logic       cfg_restart_reg;
    logic       cfg_restart_next;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_index_t'(paddr[4:2]);

    always_comb begin
        cfg_next = cfg_reg;
        idx_ok   = 1'b1;
        prdata   = '0;
        unique case (idx)
            REG_SKIP_BITS: begin
                prdata = {24'd0, cfg_reg.skip_bits};
                cfg_next.skip_bits = pwdata[7:0];
            end
            REG_OUTPUT_LENGTH: begin
                prdata = {9'd0, cfg_reg.output_length};
                cfg_next.output_length = pwdata[LEN_W-1:0];
            end
            REG_OFFSET_W1: begin
                prdata = {28'd0, cfg_reg.offset_width_1};
                cfg_next.offset_width_1 = pwdata[3:0];
            end
            REG_OFFSET_W2: begin
                prdata = {28'd0, cfg_reg.offset_width_2};
                cfg_next.offset_width_2 = pwdata[3:0];
            end
            REG_OFFSET_W3: begin
                prdata = {28'd0, cfg_reg.offset_width_3};
                cfg_next.offset_width_3 = pwdata[3:0];
            end
            REG_OFFSET_W4: begin
                prdata = {28'd0, cfg_reg.offset_width_4};
                cfg_next.offset_width_4 = pwdata[3:0];
            end
            default: begin
                idx_ok = 1'b0;
            end
        endcase
    end

    assign cfg_restart_next = wr_en && idx_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.skip_bits      <= 8'd0;
            cfg_reg.output_length  <= OUTPUT_LENGTH_RESET;
            cfg_reg.offset_width_1 <= OFFSET_WIDTH_RESET;
            cfg_reg.offset_width_2 <= OFFSET_WIDTH_RESET;
            cfg_reg.offset_width_3 <= OFFSET_WIDTH_RESET;
            cfg_reg.offset_width_4 <= OFFSET_WIDTH_RESET;
        end else if (wr_en && idx_ok) begin
            cfg_reg <= cfg_next;
        end
    end

    // The restart strobe is registered and rises once the new value is held.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_restart_reg <= 1'b0;
        end else begin
            cfg_restart_reg <= cfg_restart_next;
        end
    end

    assign cfg         = cfg_reg;
    assign cfg_restart = cfg_restart_reg;

endmodule

### hdl/blzd_front.sv
// ----------------------------------------------------------------------------
// blzd_front
// Accepts input transactions and queues them for the decode engine.
// ----------------------------------------------------------------------------
module blzd_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_command,
    input  logic [7:0]      s_packed_byte,
    output logic            q_valid,
    output blzd_pkg::item_t q_item,
    input  logic            q_pop
);
    import blzd_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= '{command: s_command, pbyte: s_packed_byte};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### hdl/blzd_back.sv
// ----------------------------------------------------------------------------
// blzd_back
// Decode engine: bit buffer, field sequencer, history window, result register.
// ----------------------------------------------------------------------------
module blzd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  blzd_pkg::cfg_t                cfg,
    input  logic                          cfg_restart,
    input  logic                          q_valid,
    input  blzd_pkg::item_t               q_item,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_byte_valid,
    output logic [7:0]                    m_out_byte,
    output logic [blzd_pkg::ADDR_W-1:0]   m_out_address,
    output logic                          m_need_byte,
    output logic                          m_done_res
);
    import blzd_pkg::*;

    logic [7:0] hist_mem [WINDOW_DEPTH];
    logic [7:0] hist_rdata_reg;

    phase_t             phase_reg, phase_next;
    logic [7:0]         bit_shift_reg, bit_shift_next;
    logic [3:0]         bits_left_reg, bits_left_next;
    logic [FIELD_W-1:0] accum_reg, accum_next;
    logic [7:0]         fbl_reg, fbl_next;
    logic [LEN_W-1:0]   run_reg, run_next;
    logic [FIELD_W-1:0] ofs_reg, ofs_next;
    logic [LEN_W-1:0]   brem_reg, brem_next;
    logic               busy_reg, busy_next;
    logic               rd_pend_reg, rd_pend_next;

    logic               out_valid_reg, out_valid_next;
    logic               o_bv_reg, o_bv_next;
    logic [7:0]         o_byte_reg, o_byte_next;
    logic [ADDR_W-1:0]  o_addr_reg, o_addr_next;
    logic               o_need_reg, o_need_next;
    logic               o_done_reg, o_done_next;

    logic               fin;
    logic               out_free;
    logic               mem_we;
    logic               mem_re;
    logic [7:0]         mem_wdata;
    logic [LEN_W-1:0]   emit_addr;
    logic [LEN_W-1:0]   run_dec;
    logic [LEN_W:0]     src_sum;
    logic               src_ok;
    logic [7:0]         copy_val;
    logic [LEN_W-1:0]   lit_sum;
    logic [LEN_W-1:0]   ext_sum;

    assign out_free  = !out_valid_reg || m_ready;
    assign emit_addr = brem_reg - 23'd1;
    assign run_dec   = run_reg - 23'd1;
    assign src_sum   = {1'b0, brem_reg} + {9'd0, ofs_reg};
    assign src_ok    = src_sum < {1'b0, cfg.output_length};
    assign copy_val  = src_ok ? hist_rdata_reg : 8'd0;
    assign lit_sum   = run_reg + {21'd0, accum_reg[1:0]};
    assign ext_sum   = run_reg + {20'd0, accum_reg[2:0]};

    always_comb begin
        phase_next     = phase_reg;
        bit_shift_next = bit_shift_reg;
        bits_left_next = bits_left_reg;
        accum_next     = accum_reg;
        fbl_next       = fbl_reg;
        run_next       = run_reg;
        ofs_next       = ofs_reg;
        brem_next      = brem_reg;
        busy_next      = busy_reg;
        rd_pend_next   = rd_pend_reg;
        fin            = 1'b0;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wdata      = 8'd0;
        o_bv_next      = 1'b0;
        o_byte_next    = 8'd0;
        o_addr_next    = '0;
        o_need_next    = 1'b0;

        if (busy_reg) begin
            if (brem_reg == '0) begin
                phase_next = PH_DONE;
                fin        = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_DONE: begin
                        fin = 1'b1;
                    end
                    PH_COPY: begin
                        if (!rd_pend_reg) begin
                            mem_re       = 1'b1;
                            rd_pend_next = 1'b1;
                        end else begin
                            rd_pend_next = 1'b0;
                            run_next     = run_dec;
                            mem_we       = 1'b1;
                            mem_wdata    = copy_val;
                            o_bv_next    = 1'b1;
                            o_byte_next  = copy_val;
                            o_addr_next  = emit_addr[ADDR_W-1:0];
                            brem_next    = emit_addr;
                            fin          = 1'b1;
                            if (emit_addr == '0) begin
                                phase_next = PH_DONE;
                            end else if (run_dec == '0) begin
                                phase_next = PH_FLAG;
                                accum_next = '0;
                                fbl_next   = 8'd1;
                            end
                        end
                    end
                    PH_SKIP: begin
                        if (fbl_reg >= cfg.skip_bits) begin
                            phase_next = PH_FLAG;
                            accum_next = '0;
                            fbl_next   = 8'd1;
                        end else if (bits_left_reg == 4'd0) begin
                            o_need_next = 1'b1;
                            fin         = 1'b1;
                        end else begin
                            bit_shift_next = bit_shift_reg >> 1;
                            bits_left_next = bits_left_reg - 4'd1;
                            fbl_next       = fbl_reg + 8'd1;
                        end
                    end
                    default: begin
                        if (fbl_reg != 8'd0) begin
                            if (bits_left_reg == 4'd0) begin
                                o_need_next = 1'b1;
                                fin         = 1'b1;
                            end else begin
                                accum_next     = {accum_reg[FIELD_W-2:0], bit_shift_reg[0]};
                                bit_shift_next = bit_shift_reg >> 1;
                                bits_left_next = bits_left_reg - 4'd1;
                                fbl_next       = fbl_reg - 8'd1;
                            end
                        end else begin
                            accum_next = '0;
                            unique case (phase_reg)
                                PH_FLAG: begin
                                    if (accum_reg == '0) begin
                                        run_next = 23'd1;
                                        if (23'd1 < brem_reg) begin
                                            phase_next = PH_LITLEN;
                                            fbl_next   = 8'd2;
                                        end else begin
                                            phase_next = PH_LITBYTE;
                                            fbl_next   = {4'd0, BYTE_BITS};
                                        end
                                    end else begin
                                        phase_next = PH_MLEN;
                                        fbl_next   = 8'd2;
                                    end
                                end
                                PH_LITLEN: begin
                                    run_next = lit_sum;
                                    if (accum_reg[1:0] == 2'd3 && lit_sum < brem_reg) begin
                                        phase_next = PH_LITLEN;
                                        fbl_next   = 8'd2;
                                    end else begin
                                        phase_next = PH_LITBYTE;
                                        fbl_next   = {4'd0, BYTE_BITS};
                                    end
                                end
                                PH_LITBYTE: begin
                                    run_next    = run_dec;
                                    mem_we      = 1'b1;
                                    mem_wdata   = accum_reg[7:0];
                                    o_bv_next   = 1'b1;
                                    o_byte_next = accum_reg[7:0];
                                    o_addr_next = emit_addr[ADDR_W-1:0];
                                    brem_next   = emit_addr;
                                    fin         = 1'b1;
                                    if (emit_addr == '0) begin
                                        phase_next = PH_DONE;
                                    end else if (run_dec == '0) begin
                                        phase_next = PH_MLEN;
                                        fbl_next   = 8'd2;
                                    end else begin
                                        phase_next = PH_LITBYTE;
                                        fbl_next   = {4'd0, BYTE_BITS};
                                    end
                                end
                                PH_MLEN: begin
                                    run_next   = {21'd0, accum_reg[1:0]} + 23'd1;
                                    phase_next = PH_MOFS;
                                    case (accum_reg[1:0])
                                        2'd0: fbl_next = {4'd0, cfg.offset_width_1};
                                        2'd1: fbl_next = {4'd0, cfg.offset_width_2};
                                        2'd2: fbl_next = {4'd0, cfg.offset_width_3};
                                        default: begin
                                            phase_next = PH_MFLAG;
                                            fbl_next   = 8'd1;
                                        end
                                    endcase
                                end
                                PH_MFLAG: begin
                                    phase_next = PH_MOFS;
                                    fbl_next   = (accum_reg != '0) ?
                                                 {4'd0, cfg.offset_width_4} :
                                                 {4'd0, SHORT_OFFSET_WIDTH};
                                end
                                PH_MOFS: begin
                                    ofs_next = accum_reg;
                                    if (run_reg == 23'd4 && run_reg < brem_reg) begin
                                        phase_next = PH_MEXT;
                                        fbl_next   = 8'd3;
                                    end else begin
                                        run_next   = run_reg + 23'd1;
                                        phase_next = PH_COPY;
                                    end
                                end
                                PH_MEXT: begin
                                    if (accum_reg[2:0] == 3'd7 && ext_sum < brem_reg) begin
                                        run_next   = ext_sum;
                                        phase_next = PH_MEXT;
                                        fbl_next   = 8'd3;
                                    end else begin
                                        run_next   = ext_sum + 23'd1;
                                        phase_next = PH_COPY;
                                    end
                                end
                                default: begin
                                    phase_next = PH_DONE;
                                end
                            endcase
                        end
                    end
                endcase
            end
            if (fin) begin
                busy_next = 1'b0;
            end
        end else if (q_valid && out_free) begin
            q_pop = 1'b1;
            if (!q_item.command) begin
                bit_shift_next = q_item.pbyte;
                bits_left_next = BYTE_BITS;
                fin            = 1'b1;
            end else begin
                busy_next = 1'b1;
            end
        end

        o_done_next = (brem_next == '0);

        if (fin) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[emit_addr[WIN_AW-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            hist_rdata_reg <= hist_mem[src_sum[WIN_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (fin) begin
            o_bv_reg   <= o_bv_next;
            o_byte_reg <= o_byte_next;
            o_addr_reg <= o_addr_next;
            o_need_reg <= o_need_next;
            o_done_reg <= o_done_next;
        end
        bit_shift_reg <= bit_shift_next;
        accum_reg     <= accum_next;
        ofs_reg       <= ofs_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SKIP;
            bits_left_reg <= 4'd0;
            fbl_reg       <= 8'd0;
            run_reg       <= '0;
            brem_reg      <= OUTPUT_LENGTH_RESET;
            busy_reg      <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (cfg_restart) begin
            phase_reg     <= PH_SKIP;
            bits_left_reg <= 4'd0;
            fbl_reg       <= 8'd0;
            run_reg       <= '0;
            brem_reg      <= cfg.output_length;
            busy_reg      <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= out_valid_next;
        end else begin
            phase_reg     <= phase_next;
            bits_left_reg <= bits_left_next;
            fbl_reg       <= fbl_next;
            run_reg       <= run_next;
            brem_reg      <= brem_next;
            busy_reg      <= busy_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_byte_valid  = o_bv_reg;
    assign m_out_byte    = o_byte_reg;
    assign m_out_address = o_addr_reg;
    assign m_need_byte   = o_need_reg;
    assign m_done_res    = o_done_reg;

`ifndef SYNTHESIS
    a_busy_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !out_valid_reg)
        else $error("Engine is busy while a result still waits.");
    a_read_in_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (phase_reg == PH_COPY))
        else $error("Window read pending outside a copy.");
    a_byte_not_need: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && o_bv_reg) |-> !o_need_reg)
        else $error("Result carries both a byte and a byte request.");
    a_bits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_left_reg <= BYTE_BITS)
        else $error("Bit buffer count exceeds one byte.");
`endif

endmodule

### hdl/backward_lz_bit_decompressor.sv
// ----------------------------------------------------------------------------
// backward_lz_bit_decompressor
// Top level: register file, input queue and decode engine.
// ----------------------------------------------------------------------------
// A supply transaction is popped from the queue and its result is loaded into
// the result register at the same edge; supplies can follow back to back while
// m_ready takes each result. An advance steps through one bit or field decision
// at a time, and in a copy each byte waits for a history window read.
// Reset is synchronous and active low; the history window is not cleared.
module backward_lz_bit_decompressor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [blzd_pkg::CFG_AW-1:0]   paddr,
    input  logic [blzd_pkg::CFG_DW-1:0]   pwdata,
    output logic [blzd_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [7:0]                    s_packed_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_byte_valid,
    output logic [7:0]                    m_out_byte,
    output logic [blzd_pkg::ADDR_W-1:0]   m_out_address,
    output logic                          m_need_byte,
    output logic                          m_done_res
);
    import blzd_pkg::*;

    cfg_t  cfg;
    logic  cfg_restart;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    blzd_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cfg         (cfg),
        .cfg_restart (cfg_restart)
    );

    blzd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_packed_byte (s_packed_byte),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    blzd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .cfg_restart   (cfg_restart),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_byte_valid  (m_byte_valid),
        .m_out_byte    (m_out_byte),
        .m_out_address (m_out_address),
        .m_need_byte   (m_need_byte),
        .m_done_res    (m_done_res)
    );

endmodule
